/* rtl/core/rmfi_pkg.sv */
// ----------------------------------------------------------------------------
// rmfi_pkg: shared types and constants of the mesh face indexer
// Holds the index width, the level width, the walk phase codes and the
// structs that pass walk state and face results between the modules.
// ----------------------------------------------------------------------------
package rmfi_pkg;

	localparam int IDX_W         = 15;
	localparam int LEVEL_W       = 3;
	localparam int ELVL_W        = 4;
	localparam int MAX_LEVEL_DEF = 6;

	typedef enum logic [1:0] {
		PH_NORTH = 2'd0,
		PH_BAND  = 2'd1,
		PH_SOUTH = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [IDX_W-1:0]  ring_start;
		logic              pos_first;
		logic              pos_last;
	} walk_state_t;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_a;
		logic [IDX_W-1:0] vertex_b;
		logic [IDX_W-1:0] vertex_c;
		logic [IDX_W-1:0] vertex_d;
		logic             is_quad;
		logic             last_face;
	} face_t;

endpackage

/* rtl/core/rmfi_req_if.sv */
// ----------------------------------------------------------------------------
// rmfi_req_if: request channel of the mesh face indexer
// One beat asks for one face; restart selects the first face of the mesh.
// ----------------------------------------------------------------------------
interface rmfi_req_if;

	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);

endinterface

/* rtl/core/rmfi_face_if.sv */
// ----------------------------------------------------------------------------
// rmfi_face_if: face channel of the mesh face indexer
// One beat carries the vertex indices of one face and its flags.
// ----------------------------------------------------------------------------
interface rmfi_face_if;

	logic                       valid;
	logic                       ready;
	logic [rmfi_pkg::IDX_W-1:0] vertex_a;
	logic [rmfi_pkg::IDX_W-1:0] vertex_b;
	logic [rmfi_pkg::IDX_W-1:0] vertex_c;
	logic [rmfi_pkg::IDX_W-1:0] vertex_d;
	logic                       is_quad;
	logic                       last_face;

	modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
		output vertex_d, output is_quad, output last_face, input ready);
	modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
		input vertex_d, input is_quad, input last_face, output ready);

endinterface

/* rtl/core/rmfi_walk.sv */
// ----------------------------------------------------------------------------
// rmfi_walk: level register and face walk counters
// Holds the level, the phase, the position in the ring, the band count and
// the first vertex of the current upper ring, and steps all but the level once per beat.
// ----------------------------------------------------------------------------
module rmfi_walk #(
	parameter int MAX_LEVEL = rmfi_pkg::MAX_LEVEL_DEF,
	parameter int POS_W     = MAX_LEVEL + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rmfi_pkg::LEVEL_W-1:0]  cfg_data,
	input  logic                          advance,
	input  logic                          restart,
	output logic [rmfi_pkg::ELVL_W-1:0]   eff_level,
	output logic [POS_W-1:0]              pos,
	output rmfi_pkg::walk_state_t         state
);
	import rmfi_pkg::*;

	localparam int BAND_W = MAX_LEVEL + 1;

	logic [LEVEL_W-1:0]  level_q;
	phase_t              phase_q;
	logic [POS_W-1:0]    pos_q;
	logic [BAND_W-1:0]   band_q;
	logic [IDX_W-1:0]    start_q;

	logic [ELVL_W-1:0]   shift_down;
	logic [POS_W-1:0]    cols_m1;
	logic [BAND_W-1:0]   rows_m3;
	logic [IDX_W-1:0]    cols;
	phase_t              cur_phase;
	logic [POS_W-1:0]    cur_pos;
	logic [BAND_W-1:0]   cur_band;
	logic [IDX_W-1:0]    cur_start;
	phase_t              nxt_phase;
	logic [POS_W-1:0]    nxt_pos;
	logic [BAND_W-1:0]   nxt_band;
	logic [IDX_W-1:0]    nxt_start;

	// Levels above the supported maximum saturate.
	assign eff_level = ({1'b0, level_q} > ELVL_W'(MAX_LEVEL)) ? ELVL_W'(MAX_LEVEL)
		: {1'b0, level_q};
	assign shift_down = ELVL_W'(MAX_LEVEL) - eff_level;
	assign cols_m1    = {POS_W{1'b1}} >> shift_down;
	assign rows_m3    = ({BAND_W{1'b1}} >> shift_down) - BAND_W'(2);
	assign cols       = IDX_W'(cols_m1) + IDX_W'(1);

	// A restart beat sees the walk as if it had just been reset; an unused
	// phase code is handled the same way.
	always_comb begin
		if (restart || !(phase_q == PH_NORTH || phase_q == PH_BAND || phase_q == PH_SOUTH)) begin
			cur_phase = PH_NORTH;
			cur_pos   = '0;
			cur_band  = '0;
			cur_start = IDX_W'(1);
		end else begin
			cur_phase = phase_q;
			cur_pos   = pos_q;
			cur_band  = band_q;
			cur_start = start_q;
		end
	end

	assign pos              = cur_pos;
	assign state.phase      = cur_phase;
	assign state.ring_start = cur_start;
	assign state.pos_first  = (cur_pos == '0);
	assign state.pos_last   = (cur_pos == cols_m1);

	always_comb begin
		nxt_phase = cur_phase;
		nxt_pos   = cur_pos + POS_W'(1);
		nxt_band  = cur_band;
		nxt_start = cur_start;
		if (state.pos_last) begin
			nxt_pos = '0;
			case (cur_phase)
				PH_NORTH: begin
					nxt_start = IDX_W'(1);
					nxt_band  = '0;
					nxt_phase = (eff_level != '0) ? PH_BAND : PH_SOUTH;
				end
				PH_BAND: begin
					nxt_band  = cur_band + BAND_W'(1);
					nxt_start = cur_start + cols;
					if (cur_band == rows_m3) begin
						nxt_phase = PH_SOUTH;
					end
				end
				default: begin
					nxt_phase = PH_NORTH;
					nxt_band  = '0;
					nxt_start = IDX_W'(1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			phase_q <= PH_NORTH;
			pos_q   <= '0;
			band_q  <= '0;
			start_q <= IDX_W'(1);
		end else if (cfg_we) begin
			level_q <= cfg_data;
			phase_q <= PH_NORTH;
			pos_q   <= '0;
			band_q  <= '0;
			start_q <= IDX_W'(1);
		end else if (advance) begin
			phase_q <= nxt_phase;
			pos_q   <= nxt_pos;
			band_q  <= nxt_band;
			start_q <= nxt_start;
		end
	end

endmodule

/* rtl/core/rmfi_face.sv */
// ----------------------------------------------------------------------------
// rmfi_face: face vertex arithmetic
// Forms the vertex indices of the current face from the walk state with a
// few 15-bit additions; all indices wrap modulo the index width.
// ----------------------------------------------------------------------------
module rmfi_face #(
	parameter int MAX_LEVEL = rmfi_pkg::MAX_LEVEL_DEF,
	parameter int POS_W     = MAX_LEVEL + 2
) (
	input  logic [rmfi_pkg::ELVL_W-1:0] eff_level,
	input  logic [POS_W-1:0]            pos,
	input  rmfi_pkg::walk_state_t       state,
	output rmfi_pkg::face_t             face
);
	import rmfi_pkg::*;

	logic [IDX_W-1:0] cols;
	logic [IDX_W-1:0] p;
	logic [IDX_W-1:0] s;
	logic [IDX_W-1:0] t;
	logic [IDX_W-1:0] south;
	logic [4:0]       sq_shift;

	assign cols     = IDX_W'(1) << eff_level << 2;
	assign p        = IDX_W'(pos);
	assign s        = state.ring_start;
	assign t        = s + p - IDX_W'(1);
	// South pole index is (rows - 1) * cols + 1 = 2^(2L+3) - cols + 1.
	assign sq_shift = {eff_level, 1'b0} + 5'd3;
	assign south    = (IDX_W'(1) << sq_shift) - cols + IDX_W'(1);

	always_comb begin
		face = '0;
		case (state.phase)
			PH_BAND: begin
				face.is_quad = 1'b1;
				if (state.pos_first) begin
					// Seam quad closes the band across the ring's end.
					face.vertex_a = s + cols - IDX_W'(1);
					face.vertex_b = s + {cols[IDX_W-2:0], 1'b0} - IDX_W'(1);
					face.vertex_c = s + cols;
					face.vertex_d = s;
				end else begin
					face.vertex_a = t;
					face.vertex_b = t + cols;
					face.vertex_c = t + cols + IDX_W'(1);
					face.vertex_d = t + IDX_W'(1);
				end
			end
			PH_SOUTH: begin
				face.vertex_b  = south;
				face.last_face = state.pos_last;
				if (state.pos_first) begin
					face.vertex_a = s + cols - IDX_W'(1);
					face.vertex_c = s;
				end else begin
					face.vertex_a = t;
					face.vertex_c = s + p;
				end
			end
			default: begin
				if (state.pos_first) begin
					face.vertex_b = cols;
					face.vertex_c = IDX_W'(1);
				end else begin
					face.vertex_b = p;
					face.vertex_c = p + IDX_W'(1);
				end
			end
		endcase
	end

endmodule

/* rtl/core/revolution_mesh_face_indexer_top.sv */
// ----------------------------------------------------------------------------
// revolution_mesh_face_indexer_top: face index generator for a closed
// surface of revolution
// Emits, one face per request beat, the vertex indices of a mesh made of a
// north pole, rings of vertices and a south pole.
// ----------------------------------------------------------------------------
// Every request beat yields one face beat, and a request is taken in every
// cycle in which the face output register is empty or is being drained, so
// the block sustains one face per clock. A face appears on the output in
// the cycle after its request beat, from the result register behind the
// walk counters and the vertex adders. The faces come as the north cap
// triangles (seam triangle first), then each band of quads (seam quad
// first), then the south cap triangles, whose final triangle carries
// last_face; after that the walk wraps to the north cap. A request with
// restart set returns the first north triangle and continues from there.
// Writing the level restarts the walk as well; write it only while no face
// is outstanding. Levels above MAX_LEVEL act as MAX_LEVEL. Triangles report
// vertex_d as zero.
// ----------------------------------------------------------------------------
module revolution_mesh_face_indexer_top #(
	parameter int MAX_LEVEL = rmfi_pkg::MAX_LEVEL_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rmfi_pkg::LEVEL_W-1:0] cfg_data,
	rmfi_req_if.sink                     req,
	rmfi_face_if.source                  face
);
	import rmfi_pkg::*;

	localparam int POS_W = MAX_LEVEL + 2;

	logic [ELVL_W-1:0] eff_level;
	logic [POS_W-1:0]  pos;
	walk_state_t       state;
	face_t             face_c;
	face_t             face_s1;
	logic              valid_s1;
	logic              accept;

	// The output register is free when it is empty or its beat leaves now.
	assign req.ready = !valid_s1 || face.ready;
	assign accept    = req.valid && req.ready;

	// The walk counters advance on every accepted request beat without a level write.
	rmfi_walk #(
		.MAX_LEVEL (MAX_LEVEL),
		.POS_W     (POS_W)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.restart   (req.restart),
		.eff_level (eff_level),
		.pos       (pos),
		.state     (state)
	);

	// The vertex adders turn the current walk position into a face.
	rmfi_face #(
		.MAX_LEVEL (MAX_LEVEL),
		.POS_W     (POS_W)
	) u_face (
		.eff_level (eff_level),
		.pos       (pos),
		.state     (state),
		.face      (face_c)
	);

	// Result register: holds a face until the consumer takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (face.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			face_s1 <= face_c;
		end
	end

	assign face.valid     = valid_s1;
	assign face.vertex_a  = face_s1.vertex_a;
	assign face.vertex_b  = face_s1.vertex_b;
	assign face.vertex_c  = face_s1.vertex_c;
	assign face.vertex_d  = face_s1.vertex_d;
	assign face.is_quad   = face_s1.is_quad;
	assign face.last_face = face_s1.last_face;

	// A restart beat always produces the north seam triangle.
	a_restart_north: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.restart |-> face_c.vertex_a == '0 && face_c.vertex_c == IDX_W'(1)
			&& !face_c.is_quad)
		else $error("restart did not select the north seam triangle");

	// After the last face the walk is back at the north seam triangle.
	a_wrap_north: assert property (@(posedge clk) disable iff (!arst_n)
		accept && face_c.last_face |=> face_c.vertex_a == '0 && face_c.vertex_c == IDX_W'(1)
			&& !face_c.is_quad)
		else $error("walk did not wrap to the north cap after the last face");

	// Triangles carry no fourth vertex.
	a_tri_no_d: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !face_s1.is_quad |-> face_s1.vertex_d == '0)
		else $error("triangle face with nonzero fourth vertex");

	// The last face of the mesh is a south triangle, never a quad.
	a_last_is_tri: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && face_s1.last_face |-> !face_s1.is_quad)
		else $error("last face flagged on a quad");

endmodule

/* dv/rmfi_face_checker.sv */
// ----------------------------------------------------------------------------
// rmfi_face_checker: face order checker for the mesh face indexer
// Follows the level writes and the request beats, walks its own copy of the
// mesh, and compares every face beat field by field with the oldest face due.
// ----------------------------------------------------------------------------
module rmfi_face_checker #(
	parameter int MAX_LEVEL = rmfi_pkg::MAX_LEVEL_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rmfi_pkg::LEVEL_W-1:0] cfg_data,
	rmfi_req_if                          req,
	rmfi_face_if                         face,
	output int                           n_errors,
	output int                           n_pending,
	output int                           n_faces,
	output int                           n_quads,
	output int                           n_mesh_ends
);

	timeunit 1ns;
	timeprecision 1ps;

	import rmfi_pkg::*;

	logic [LEVEL_W-1:0] level_q;
	phase_t             walk_phase;
	logic [7:0]         ring_pos;
	logic [6:0]         bands_done;
	logic [IDX_W-1:0]   upper_ring;
	face_t              faces_due[$];

	function automatic void restart_walk();
		walk_phase = PH_NORTH;
		ring_pos   = '0;
		bands_done = '0;
		upper_ring = IDX_W'(1);
	endfunction

	// Returns the face that the walk is at and steps the walk to the next face.
	function automatic face_t next_face(input logic restart);
		face_t f;
		int lv, rows, cols, south, s, p, t;
		f = '0;
		lv = (int'(level_q) > MAX_LEVEL) ? MAX_LEVEL : int'(level_q);
		rows = 1 << (lv + 1);
		cols = 1 << (lv + 2);
		south = (rows - 1) * cols + 1;
		if (restart || walk_phase > PH_SOUTH || int'(ring_pos) >= cols)
			restart_walk();
		s = int'(upper_ring);
		p = int'(ring_pos);
		case (walk_phase)
			PH_BAND: begin
				f.is_quad = 1'b1;
				if (p == 0) begin
					f.vertex_a = IDX_W'(s + cols - 1);
					f.vertex_b = IDX_W'(s + 2 * cols - 1);
					f.vertex_c = IDX_W'(s + cols);
					f.vertex_d = IDX_W'(s);
				end else begin
					t = s + p - 1;
					f.vertex_a = IDX_W'(t);
					f.vertex_b = IDX_W'(t + cols);
					f.vertex_c = IDX_W'(t + cols + 1);
					f.vertex_d = IDX_W'(t + 1);
				end
			end
			PH_SOUTH: begin
				f.vertex_b = IDX_W'(south);
				if (p == 0) begin
					f.vertex_a = IDX_W'(s + cols - 1);
					f.vertex_c = IDX_W'(s);
				end else begin
					f.vertex_a = IDX_W'(s + p - 1);
					f.vertex_c = IDX_W'(s + p);
				end
				f.last_face = (p == cols - 1);
			end
			default: begin
				// The seam triangle closes the north ring between its last and
				// its first vertex.
				f.vertex_b = (p == 0) ? IDX_W'(cols) : IDX_W'(p);
				f.vertex_c = (p == 0) ? IDX_W'(1) : IDX_W'(p + 1);
			end
		endcase

		p = p + 1;
		if (p >= cols) begin
			p = 0;
			case (walk_phase)
				PH_NORTH: begin
					upper_ring = IDX_W'(1);
					bands_done = '0;
					walk_phase = (rows > 2) ? PH_BAND : PH_SOUTH;
				end
				PH_BAND: begin
					bands_done = bands_done + 7'd1;
					upper_ring = upper_ring + IDX_W'(cols);
					if (int'(bands_done) >= rows - 2)
						walk_phase = PH_SOUTH;
				end
				default: begin
					restart_walk();
				end
			endcase
		end
		ring_pos = 8'(p);
		return f;
	endfunction

	task automatic report_face(input string what, input face_t exp, input face_t got);
		n_errors++;
		if (n_errors <= 10)
			$display("[%0t] face error (%s): expected a=%0d b=%0d c=%0d d=%0d quad=%0b last=%0b,",
				$time, what, exp.vertex_a, exp.vertex_b, exp.vertex_c, exp.vertex_d,
				exp.is_quad, exp.last_face, "\n    got a=%0d b=%0d c=%0d d=%0d quad=%0b last=%0b",
				got.vertex_a, got.vertex_b, got.vertex_c, got.vertex_d, got.is_quad,
				got.last_face);
	endtask

	always @(posedge clk or negedge arst_n) begin
		face_t got, exp;
		string diff;
		if (!arst_n) begin
			level_q = '0;
			restart_walk();
			faces_due.delete();
			n_errors = 0;
			n_pending = 0;
			n_faces = 0;
			n_quads = 0;
			n_mesh_ends = 0;
		end else begin
			// A face beat always belongs to an earlier request, so it is
			// checked before this edge's request is queued.
			if (face.valid && face.ready) begin
				got.vertex_a  = face.vertex_a;
				got.vertex_b  = face.vertex_b;
				got.vertex_c  = face.vertex_c;
				got.vertex_d  = face.vertex_d;
				got.is_quad   = face.is_quad;
				got.last_face = face.last_face;
				if (faces_due.size() == 0) begin
					report_face("no face due", '0, got);
				end else begin
					exp = faces_due.pop_front();
					diff = "";
					if (got.vertex_a !== exp.vertex_a) diff = {diff, " vertex_a"};
					if (got.vertex_b !== exp.vertex_b) diff = {diff, " vertex_b"};
					if (got.vertex_c !== exp.vertex_c) diff = {diff, " vertex_c"};
					if (got.vertex_d !== exp.vertex_d) diff = {diff, " vertex_d"};
					if (got.is_quad !== exp.is_quad) diff = {diff, " is_quad"};
					if (got.last_face !== exp.last_face) diff = {diff, " last_face"};
					if (diff != "")
						report_face({"wrong", diff}, exp, got);
					n_faces++;
					if (exp.is_quad)
						n_quads++;
					if (exp.last_face)
						n_mesh_ends++;
				end
			end
			if (cfg_we) begin
				level_q = cfg_data;
				restart_walk();
			end
			if (req.valid && req.ready)
				faces_due.push_back(next_face(req.restart));
			n_pending = faces_due.size();
		end
	end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of the mesh face indexer
// Drives face requests at every subdivision level with random restarts and
// random gaps and stalls on both channels, while a checker beside the block
// walks the mesh on its own and compares each face beat.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import rmfi_pkg::*;

	// Cycles without any accepted beat before the run is declared hung. The
	// longest quiet stretch of a correct run is a sender gap or a receiver
	// stall plus a level write, so this is far above it.
	localparam int HANG_LIMIT = 2000;

	// Random phases: level written, number of requests, and the chance of a
	// restart per request in parts per thousand. The small levels run whole
	// meshes and wrap; level 3 runs one full mesh without any restart. The
	// large levels stay short, and level 5 runs on past its north cap into
	// the bands. Level 7 checks that the level saturates.
	localparam int N_PHASES = 8;
	localparam int PHASE_LEVEL [N_PHASES] = '{1, 2, 3, 0, 4, 5, 6, 7};
	localparam int PHASE_ITEMS [N_PHASES] = '{80, 140, 520, 40, 90, 160, 60, 60};
	localparam int PHASE_ODDS  [N_PHASES] = '{15, 5, 0, 60, 5, 0, 30, 30};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LEVEL_W-1:0] cfg_data;

	int n_errors;
	int n_pending;
	int n_faces;
	int n_quads;
	int n_mesh_ends;
	int idle_cycles;

	// Per-phase switches for the sender gaps and the receiver stalls, so
	// that some phases run at full rate.
	bit gaps_on;
	bit stalls_on;

	rmfi_req_if  req_ch();
	rmfi_face_if face_ch();

	revolution_mesh_face_indexer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.face     (face_ch)
	);

	rmfi_face_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.face        (face_ch),
		.n_errors    (n_errors),
		.n_pending   (n_pending),
		.n_faces     (n_faces),
		.n_quads     (n_quads),
		.n_mesh_ends (n_mesh_ends)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Sends one request beat. It starts and ends at a falling edge. Valid
	// stays high from one beat to the next unless a gap is drawn, so it is
	// never lowered and raised within the same time step.
	task automatic request_face(input logic restart);
		int gap, roll;
		gap = 0;
		if (gaps_on) begin
			roll = $urandom_range(0, 99);
			if (roll >= 90)
				gap = $urandom_range(8, 40);
			else if (roll >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.restart <= restart;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Waits at falling edges until every face asked for has come back, then
	// lets the output register settle.
	task automatic drain_faces();
		while (n_pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Writes the level. It is only called while no face is outstanding.
	task automatic set_level(input int lv);
		cfg_we   <= 1'b1;
		cfg_data <= LEVEL_W'(lv);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: ready is held high for a random stretch, then dropped for a
	// short stall, now and then a long one. With stalls switched off it
	// simply stays high.
	initial begin
		int hold, stall;
		face_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
				: $urandom_range(1, 12);
			stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
				: $urandom_range(1, 3);
			face_ch.ready <= 1'b1;
			repeat (hold) @(negedge clk);
			if (stalls_on) begin
				face_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	// Watchdog: any accepted beat on either channel resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (face_ch.valid && face_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("Hang: no beat accepted for %0d cycles", idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_data       = '0;
		req_ch.valid   = 1'b0;
		req_ch.restart = 1'b0;
		idle_cycles    = 0;
		gaps_on        = 1'b1;
		stalls_on      = 1'b1;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset level of zero, where there are no bands:
		// a whole mesh of north and south triangles, the last face flag, and
		// the wrap back to the north seam triangle.
		repeat (10) request_face(1'b0);
		// A restart in the middle of the walk, then another after two plain
		// requests.
		request_face(1'b1);
		request_face(1'b0);
		request_face(1'b0);
		request_face(1'b1);
		req_ch.valid <= 1'b0;
		drain_faces();

		// Writing the level, even to the value it already has, restarts the
		// walk, which was left in the middle of the north cap.
		set_level(0);
		repeat (2) request_face(1'b0);
		req_ch.valid <= 1'b0;
		drain_faces();

		// The largest code saturates to the deepest level.
		set_level(7);
		repeat (3) request_face(1'b0);
		request_face(1'b1);
		request_face(1'b0);
		req_ch.valid <= 1'b0;
		drain_faces();

		// Random phases. Each ends with the sender holding off until every
		// face has come back, which is also when the next level is written.
		for (int i = 0; i < N_PHASES; i++) begin
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			set_level(PHASE_LEVEL[i]);
			for (int k = 0; k < PHASE_ITEMS[i]; k++)
				request_face($urandom_range(0, 999) < PHASE_ODDS[i]);
			req_ch.valid <= 1'b0;
			drain_faces();
		end

		repeat (4) @(posedge clk);
		$display("Checked %0d faces, %0d of them quads, with %0d complete meshes,",
			n_faces, n_quads, n_mesh_ends);
		$display("across levels 0 to 7 with restarts, level rewrites, gaps and stalls.");
		if (n_errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d face errors", n_errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/rmfi_pkg.sv
rtl/core/rmfi_req_if.sv
rtl/core/rmfi_face_if.sv
rtl/core/rmfi_walk.sv
rtl/core/rmfi_face.sv
rtl/core/revolution_mesh_face_indexer_top.sv
dv/rmfi_face_checker.sv
dv/tb.sv
